>>> hdl/jsf32_bounded_random_top_defines.svh
`ifndef JSF32_BOUNDED_RANDOM_TOP_DEFINES_SVH
`define JSF32_BOUNDED_RANDOM_TOP_DEFINES_SVH

// checks sampled on clk_i, masked while rst_ni is low
`define JBR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checks sampled on clk_i, also active during reset
`define JBR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> hdl/jsf32br_pkg.sv
package jsf32br_pkg;

  localparam int unsigned DATA_W          = 32;
  localparam int unsigned DIV_STEPS       = 32;
  localparam int unsigned DRAW_MAX_ROUNDS = 64;
  localparam int unsigned ROT_B           = 27;
  localparam int unsigned ROT_C           = 17;

  localparam logic [DATA_W-1:0] SEED_A_INIT = 32'hf1ea5eed;

  localparam logic CMD_DRAW   = 1'b0;
  localparam logic CMD_RESEED = 1'b1;

  typedef logic [DATA_W-1:0] word_t;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
  } jsf_state_t;

  function automatic word_t rotl(input word_t v, input int unsigned k);
    rotl = (v << k) | (v >> (DATA_W - k));
  endfunction

  // one generator round; the new d is the round output
  function automatic jsf_state_t jsf_round(input jsf_state_t s);
    word_t      e;
    jsf_state_t n;
    e   = s.a - rotl(s.b, ROT_B);
    n.a = s.b ^ rotl(s.c, ROT_C);
    n.b = s.c + s.d;
    n.c = s.d + e;
    n.d = e + n.a;
    jsf_round = n;
  endfunction

endpackage

>>> hdl/jsf32_bounded_random_top.sv
// JSF32 random generator with unbiased reduction to [0, range). command 1 reseeds
// (a = 0xf1ea5eed, b = c = d = seed, then SEED_ROUNDS discarded rounds) and
// returns 0; command 0 with range 0 returns one raw 32-bit word; command 0 with
// range > 0 returns a rejection-sampled value below range. One transfer in gives
// exactly one transfer out; the block takes one item at a time. A reseed runs
// SEED_ROUNDS generator rounds and a raw draw one round; a bounded draw makes
// two 32-step passes of the shared bit-serial remainder unit, one for the
// threshold and one for the result, plus one round and one threshold check per
// generator step. A draw takes the value of its 64th round without rejecting it.
// The output register lets the next item be accepted while a result waits.
`include "jsf32_bounded_random_top_defines.svh"

module jsf32_bounded_random_top #(
  parameter int unsigned SEED_ROUNDS = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  logic [31:0] range_i,
  input  logic [31:0] seed_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] value_o
);

  localparam int unsigned MaxRounds = (SEED_ROUNDS > jsf32br_pkg::DRAW_MAX_ROUNDS) ?
                                      SEED_ROUNDS : jsf32br_pkg::DRAW_MAX_ROUNDS;
  localparam int unsigned RndW  = $clog2(MaxRounds + 1);
  localparam int unsigned StepW = $clog2(jsf32br_pkg::DIV_STEPS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SEED  = 3'd1;
  localparam logic [2:0] S_TDIV  = 3'd2;
  localparam logic [2:0] S_DRAW  = 3'd3;
  localparam logic [2:0] S_CHECK = 3'd4;
  localparam logic [2:0] S_RDIV  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]             state_q, state_d;
  logic [RndW-1:0]        rnd_q, rnd_d;
  logic [StepW-1:0]       step_q, step_d;
  logic                   raw_q, raw_d;
  jsf32br_pkg::jsf_state_t gen_q, gen_d, gen_nxt;
  jsf32br_pkg::word_t     range_q, range_d;
  jsf32br_pkg::word_t     thr_q, thr_d;
  jsf32br_pkg::word_t     dvd_q, dvd_d;
  jsf32br_pkg::word_t     rem_q, rem_d, rem_step;
  jsf32br_pkg::word_t     res_q, res_d;
  jsf32br_pkg::word_t     value_q, value_d;
  logic                   out_valid_q, out_valid_d;
  logic [32:0]            trial, diff;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;

  assign gen_nxt = jsf32br_pkg::jsf_round(gen_q);

  // restoring remainder step
  assign trial    = {rem_q, dvd_q[31]};
  assign diff     = trial - {1'b0, range_q};
  assign rem_step = diff[32] ? trial[31:0] : diff[31:0];

  always_comb begin
    state_d     = state_q;
    rnd_d       = rnd_q;
    step_d      = step_q;
    raw_d       = raw_q;
    gen_d       = gen_q;
    range_d     = range_q;
    thr_d       = thr_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    res_d       = res_q;
    value_d     = value_q;
    out_valid_d = out_valid_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          range_d = range_i;
          rnd_d   = '0;
          step_d  = '0;
          rem_d   = '0;
          raw_d   = (range_i == '0);
          if (command_i == jsf32br_pkg::CMD_RESEED) begin
            gen_d.a = jsf32br_pkg::SEED_A_INIT;
            gen_d.b = seed_i;
            gen_d.c = seed_i;
            gen_d.d = seed_i;
            state_d = S_SEED;
          end else if (range_i == '0) begin
            state_d = S_DRAW;
          end else begin
            dvd_d   = '0 - range_i;
            state_d = S_TDIV;
          end
        end
      end
      S_SEED: begin
        gen_d = gen_nxt;
        rnd_d = rnd_q + 1'b1;
        if (rnd_q == RndW'(SEED_ROUNDS - 1)) begin
          res_d   = '0;
          state_d = S_DONE;
        end
      end
      S_TDIV: begin
        rem_d  = rem_step;
        dvd_d  = {dvd_q[30:0], 1'b0};
        step_d = step_q + 1'b1;
        if (step_q == StepW'(jsf32br_pkg::DIV_STEPS - 1)) begin
          thr_d   = rem_step;
          state_d = S_DRAW;
        end
      end
      S_DRAW: begin
        gen_d = gen_nxt;
        rnd_d = rnd_q + 1'b1;
        if (raw_q) begin
          res_d   = gen_nxt.d;
          state_d = S_DONE;
        end else begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if ((gen_q.d >= thr_q) || (rnd_q == RndW'(jsf32br_pkg::DRAW_MAX_ROUNDS))) begin
          dvd_d   = gen_q.d;
          rem_d   = '0;
          step_d  = '0;
          state_d = S_RDIV;
        end else begin
          state_d = S_DRAW;
        end
      end
      S_RDIV: begin
        rem_d  = rem_step;
        dvd_d  = {dvd_q[30:0], 1'b0};
        step_d = step_q + 1'b1;
        if (step_q == StepW'(jsf32br_pkg::DIV_STEPS - 1)) begin
          res_d   = rem_step;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          value_d     = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rnd_q       <= '0;
      step_q      <= '0;
      raw_q       <= 1'b0;
      gen_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rnd_q       <= rnd_d;
      step_q      <= step_d;
      raw_q       <= raw_d;
      gen_q       <= gen_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    range_q <= range_d;
    thr_q   <= thr_d;
    dvd_q   <= dvd_d;
    rem_q   <= rem_d;
    res_q   <= res_d;
    value_q <= value_d;
  end

  `JBR_ASSERT(a_reseed_goes_seed, (in_valid_i && in_ready_o && command_i) |=> (state_q == S_SEED), "reseed transfer did not start seeding")
  `JBR_ASSERT(a_rem_below_range, ((state_q == S_TDIV) || (state_q == S_RDIV)) |-> (rem_q < range_q), "partial remainder not below range")
  `JBR_ASSERT(a_check_round_cap, (state_q == S_CHECK) |-> ((rnd_q != '0) && (rnd_q <= RndW'(jsf32br_pkg::DRAW_MAX_ROUNDS))), "draw round count out of bounds")
  `JBR_ASSERT(a_done_holds, ((state_q == S_DONE) && out_valid_o && !out_ready_i) |=> (state_q == S_DONE), "result overwrote a pending output")
  `JBR_ASSERT_RST(a_reset_no_valid, !rst_ni |-> !out_valid_o, "output valid during reset")

endmodule
